/* src/chps_pkg.sv */
// Package: types, constants and microcode ROM for the chained hash pair-sum search unit.
`default_nettype none

package chps_pkg;

  localparam int REQ_W        = 2;
  localparam int VAL_W        = 31;
  localparam int TGT_W        = 32;
  localparam int BUCKETS_DEF  = 64;
  localparam int CAPACITY_DEF = 1024;
  localparam int MOD_STEPS    = 2;
  localparam int MCNT_W       = 1;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam int UAW = 5;

  localparam logic [UAW-1:0] UA_IDLE     = 5'd0;
  localparam logic [UAW-1:0] UA_INS0     = 5'd1;
  localparam logic [UAW-1:0] UA_INS1     = 5'd2;
  localparam logic [UAW-1:0] UA_INS2     = 5'd3;
  localparam logic [UAW-1:0] UA_INS3     = 5'd4;
  localparam logic [UAW-1:0] UA_INS4     = 5'd5;
  localparam logic [UAW-1:0] UA_QRY0     = 5'd6;
  localparam logic [UAW-1:0] UA_QRY1     = 5'd7;
  localparam logic [UAW-1:0] UA_QRY2     = 5'd8;
  localparam logic [UAW-1:0] UA_QRY3     = 5'd9;
  localparam logic [UAW-1:0] UA_QRY4     = 5'd10;
  localparam logic [UAW-1:0] UA_QRY5     = 5'd11;
  localparam logic [UAW-1:0] UA_QRY6     = 5'd12;
  localparam logic [UAW-1:0] UA_QRY7     = 5'd13;
  localparam logic [UAW-1:0] UA_FIN_HIT  = 5'd14;
  localparam logic [UAW-1:0] UA_QNEXT    = 5'd15;
  localparam logic [UAW-1:0] UA_CLR0     = 5'd16;
  localparam logic [UAW-1:0] UA_CLR1     = 5'd17;
  localparam logic [UAW-1:0] UA_FIN_OK   = 5'd18;
  localparam logic [UAW-1:0] UA_FIN_FULL = 5'd19;
  localparam logic [UAW-1:0] UA_RST1     = 5'd20;
  localparam logic [UAW-1:0] UA_RST2     = 5'd21;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MOD_INIT_V,
    OP_MOD_INIT_C,
    OP_MOD_STEP,
    OP_HEAD_RD,
    OP_INSERT,
    OP_Q_INIT,
    OP_VAL_RD_I,
    OP_CUR_LD,
    OP_NODE_RD,
    OP_CUR_LINK,
    OP_I_INC,
    OP_SWEEP_INIT,
    OP_SWEEP_WR,
    OP_DONE_OK,
    OP_DONE_FULL
  } uop_t;

  typedef enum logic [3:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_FULL,
    CND_MOD_MORE,
    CND_I_DONE,
    CND_COMP_NEG,
    CND_CUR_NULL,
    CND_NO_MATCH,
    CND_SWEEP_MORE,
    CND_HIT
  } cond_t;

  typedef struct packed {
    uop_t           op;
    cond_t          cond;
    logic [UAW-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input logic [UAW-1:0] addr);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: CND_NEVER, target: UA_IDLE};
    case (addr)
      UA_INS0:     w = '{op: OP_NOP,        cond: CND_FULL,       target: UA_FIN_FULL};
      UA_INS1:     w = '{op: OP_MOD_INIT_V, cond: CND_NEVER,      target: UA_IDLE};
      UA_INS2:     w = '{op: OP_MOD_STEP,   cond: CND_MOD_MORE,   target: UA_INS2};
      UA_INS3:     w = '{op: OP_HEAD_RD,    cond: CND_NEVER,      target: UA_IDLE};
      UA_INS4:     w = '{op: OP_INSERT,     cond: CND_ALWAYS,     target: UA_FIN_OK};
      UA_QRY0:     w = '{op: OP_Q_INIT,     cond: CND_NEVER,      target: UA_IDLE};
      UA_QRY1:     w = '{op: OP_VAL_RD_I,   cond: CND_I_DONE,     target: UA_FIN_OK};
      UA_QRY2:     w = '{op: OP_MOD_INIT_C, cond: CND_COMP_NEG,   target: UA_QNEXT};
      UA_QRY3:     w = '{op: OP_MOD_STEP,   cond: CND_MOD_MORE,   target: UA_QRY3};
      UA_QRY4:     w = '{op: OP_HEAD_RD,    cond: CND_NEVER,      target: UA_IDLE};
      UA_QRY5:     w = '{op: OP_CUR_LD,     cond: CND_NEVER,      target: UA_IDLE};
      UA_QRY6:     w = '{op: OP_NODE_RD,    cond: CND_CUR_NULL,   target: UA_QNEXT};
      UA_QRY7:     w = '{op: OP_CUR_LINK,   cond: CND_NO_MATCH,   target: UA_QRY6};
      UA_FIN_HIT:  w = '{op: OP_NOP,        cond: CND_HIT,        target: UA_IDLE};
      UA_QNEXT:    w = '{op: OP_I_INC,      cond: CND_ALWAYS,     target: UA_QRY1};
      UA_CLR0:     w = '{op: OP_SWEEP_INIT, cond: CND_NEVER,      target: UA_IDLE};
      UA_CLR1:     w = '{op: OP_SWEEP_WR,   cond: CND_SWEEP_MORE, target: UA_CLR1};
      UA_FIN_OK:   w = '{op: OP_DONE_OK,    cond: CND_ALWAYS,     target: UA_IDLE};
      UA_FIN_FULL: w = '{op: OP_DONE_FULL,  cond: CND_ALWAYS,     target: UA_IDLE};
      UA_RST1:     w = '{op: OP_SWEEP_WR,   cond: CND_SWEEP_MORE, target: UA_RST1};
      UA_RST2:     w = '{op: OP_NOP,        cond: CND_ALWAYS,     target: UA_IDLE};
      default:     w = '{op: OP_NOP,        cond: CND_ALWAYS,     target: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* src/chained_hash_pair_sum_search_unit.sv */
// Top level: microcoded chained hash set with insert, clear and pair-sum query.
// Insert: done rises once the word is linked into its bucket; a full pool refuses the insert.
// Query: for each stored entry, walks the chain of its complement's bucket, skipping negative complements,
// ending early on a hit. Clear: sweeps every bucket head; an unknown request just completes. One word in flight.
// Reset: synchronous; afterwards busy stays high while bucket heads clear.
// Results are strobed for one cycle on done; a new word may be accepted in that cycle.
`default_nettype none

module chained_hash_pair_sum_search_unit
  import chps_pkg::*;
#(
  parameter int BUCKETS  = BUCKETS_DEF,
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [REQ_W-1:0]        req_type,
  input  wire logic [VAL_W-1:0]        value,
  input  wire logic signed [TGT_W-1:0] target_sum,
  output logic                         busy,
  output logic                         done,
  output logic                         found,
  output logic                         status
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = $clog2(CAPACITY);
  localparam int IW = $clog2(CAPACITY + 1);

  // bucket index: quotient by reciprocal multiply, remainder by one multiply-subtract
  localparam int RL = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
  localparam int RS = VAL_W + RL;
  localparam longint RECIP = ((longint'(1) << RS) + longint'(BUCKETS) - longint'(1))
                             / longint'(BUCKETS);
  localparam int PW = 2 * VAL_W + 1;
  localparam logic [PW-1:0] RECIP_W = PW'(RECIP);

  logic [IW-1:0]    head_mem [BUCKETS];
  logic [VAL_W-1:0] val_mem  [CAPACITY];
  logic [IW-1:0]    link_mem [CAPACITY];

  logic [UAW-1:0]          upc;
  logic [IW-1:0]           count;
  logic [IW-1:0]           idx;
  logic [IW-1:0]           cur;
  logic [BW-1:0]           sw;
  logic [BW-1:0]           rem;
  logic [MCNT_W-1:0]       mcnt;
  logic [PW-1:0]           prod;
  logic [VAL_W-1:0]        opnd;
  logic signed [TGT_W-1:0] tgt;
  logic [IW-1:0]           head_q;
  logic [VAL_W-1:0]        val_q;
  logic [IW-1:0]           link_q;

  ctrl_word_t              cw;
  logic                    jump;
  logic signed [TGT_W:0]   comp;
  logic [IW-1:0]           cur_m1;
  logic [VAL_W-1:0]        quot;
  logic [VAL_W-1:0]        rem_full;
  logic [BW-1:0]           rem_next;
  logic [UAW-1:0]          entry;
  logic [NW-1:0]           node_ra;
  logic                    head_we;
  logic [BW-1:0]           head_wa;
  logic [IW-1:0]           head_wd;

  assign cw       = ucode_rom(upc);
  assign busy     = (upc != UA_IDLE);
  assign comp     = {tgt[TGT_W-1], tgt} - $signed({2'b00, val_q});
  assign cur_m1   = cur - IW'(1);
  assign quot     = VAL_W'(prod >> RS);
  assign rem_full = opnd - quot * VAL_W'(BUCKETS);
  assign rem_next = rem_full[BW-1:0];
  assign node_ra  = (cw.op == OP_NODE_RD) ? cur_m1[NW-1:0] : idx[NW-1:0];

  always_comb begin
    case (req_type)
      REQ_INSERT: entry = UA_INS0;
      REQ_QUERY:  entry = UA_QRY0;
      REQ_CLEAR:  entry = UA_CLR0;
      default:    entry = UA_FIN_OK;
    endcase
  end

  always_comb begin
    case (cw.cond)
      CND_NEVER:      jump = 1'b0;
      CND_ALWAYS:     jump = 1'b1;
      CND_FULL:       jump = (count == IW'(CAPACITY));
      CND_MOD_MORE:   jump = (mcnt != MCNT_W'(MOD_STEPS - 1));
      CND_I_DONE:     jump = (idx == count);
      CND_COMP_NEG:   jump = comp[TGT_W];
      CND_CUR_NULL:   jump = (cur == '0);
      CND_NO_MATCH:   jump = !((val_q == opnd) && (cur_m1 != idx));
      CND_SWEEP_MORE: jump = (sw != BW'(BUCKETS - 1));
      CND_HIT:        jump = 1'b1;
      default:        jump = 1'b1;
    endcase
  end

  always_comb begin
    head_we = 1'b0;
    head_wa = rem;
    head_wd = count + IW'(1);
    case (cw.op)
      OP_INSERT: begin
        head_we = 1'b1;
      end
      OP_SWEEP_WR: begin
        head_we = 1'b1;
        head_wa = sw;
        head_wd = '0;
      end
      default: head_we = 1'b0;
    endcase
  end

  // bucket heads
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (cw.op == OP_HEAD_RD) begin
      head_q <= head_mem[rem];
    end
  end

  // node pool
  always_ff @(posedge clk) begin
    if (cw.op == OP_INSERT) begin
      val_mem[count[NW-1:0]]  <= opnd;
      link_mem[count[NW-1:0]] <= head_q;
    end
    if (cw.op == OP_VAL_RD_I || cw.op == OP_NODE_RD) begin
      val_q  <= val_mem[node_ra];
      link_q <= link_mem[node_ra];
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upc    <= UA_RST1;
      sw     <= '0;
      count  <= '0;
      done   <= 1'b0;
      found  <= 1'b0;
      status <= 1'b0;
    end else begin
      done <= (cw.op == OP_DONE_OK) || (cw.op == OP_DONE_FULL) || (cw.cond == CND_HIT);
      case (cw.op)
        OP_MOD_INIT_V: begin
          mcnt <= '0;
        end
        OP_MOD_INIT_C: begin
          opnd <= comp[VAL_W-1:0];
          mcnt <= '0;
        end
        OP_MOD_STEP: begin
          prod <= {{(PW-VAL_W){1'b0}}, opnd} * RECIP_W;
          rem  <= rem_next;
          mcnt <= mcnt + MCNT_W'(1);
        end
        OP_INSERT:     count <= count + IW'(1);
        OP_Q_INIT:     idx <= '0;
        OP_I_INC:      idx <= idx + IW'(1);
        OP_CUR_LD:     cur <= head_q;
        OP_CUR_LINK:   cur <= link_q;
        OP_SWEEP_INIT: begin
          sw    <= '0;
          count <= '0;
        end
        OP_SWEEP_WR:   sw <= sw + BW'(1);
        OP_DONE_OK: begin
          found  <= 1'b0;
          status <= 1'b0;
        end
        OP_DONE_FULL: begin
          found  <= 1'b0;
          status <= 1'b1;
        end
        default: ;
      endcase
      if (cw.cond == CND_HIT) begin
        found  <= 1'b1;
        status <= 1'b0;
      end
      if (upc == UA_IDLE) begin
        if (start) begin
          upc  <= entry;
          opnd <= value;
          tgt  <= target_sum;
        end
      end else if (jump) begin
        upc <= cw.target;
      end else begin
        upc <= upc + UAW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/chps_checker.sv */
// Port checker for the chained hash pair-sum search unit, bound to the top level.
`default_nettype none

module chps_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic found,
  input wire logic status
);

  a_rst_sweep: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("reset must start the bucket sweep with no strobe");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not make the unit busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_full_nohit: assert property (@(posedge clk) disable iff (rst)
    done && status |-> !found)
    else $error("pool-full status together with found");

endmodule

bind chained_hash_pair_sum_search_unit chps_checker u_chps_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .found  (found),
  .status (status)
);

`default_nettype wire
